/* src/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define THP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("thp assertion failed");

// Checked on every edge, reset included.
`define THP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("thp assertion failed");

`endif

/* src/thp_pkg.sv */
// ----------------------------------------------------------------------------
// thp_pkg
// Types, constants and helpers for the sensor compensation block.
// ----------------------------------------------------------------------------
package thp_pkg;

  localparam int IQ_DEPTH = 4;
  localparam int IQ_AW    = 2;
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = 1;
  localparam int DIV_BITS = 64;

  localparam logic [63:0] PRESS_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_FULL   = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE  = 64'd3125;
  localparam logic [63:0] PRESS_BIAS   = 64'h0000_8000_0000_0000;
  localparam logic [31:0] TEMP_ROUND   = 32'd128;
  localparam logic [31:0] HUM_OFFSET   = 32'd76800;
  localparam logic [31:0] HUM_ROUND    = 32'd16384;
  localparam logic [31:0] HUM_BASE     = 32'd2097152;
  localparam logic [31:0] HUM_ROUND2   = 32'd8192;
  localparam logic [31:0] HUM_HALF     = 32'd32768;
  localparam logic [31:0] HUM_MAX      = 32'd419430400;

  typedef enum logic [2:0] {
    CFG_TEMP    = 3'd0,
    CFG_PRESS_A = 3'd1,
    CFG_PRESS_B = 3'd2,
    CFG_MIXED   = 3'd3,
    CFG_HUMID   = 3'd4
  } thp_cfg_idx_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_a;
    logic [63:0] press_b;
    logic [47:0] mixed;
    logic [39:0] humid;
  } thp_coef_t;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_humid;
  } thp_raw_t;

  typedef struct packed {
    logic     valid;
    thp_raw_t item;
  } thp_fq_t;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] press_q24_8;
    logic [16:0] humid_q22_10;
    logic        press_invalid;
  } thp_res_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_ISSUE, BK_WAIT, BK_DIV, BK_PUSH
  } thp_state_t;

  typedef enum logic [4:0] {
    SP_TA, SP_TD, SP_TV2,
    SP_PSQ, SP_PX2A, SP_PX2B, SP_PX1A, SP_PX1B, SP_PDIV, SP_PNUM,
    SP_PY1, SP_PY2, SP_PFIN,
    SP_HA, SP_HB, SP_HC, SP_HD, SP_HE, SP_HV, SP_HVS, SP_HFIN
  } thp_step_t;

  typedef enum logic [2:0] {
    MP_IDLE, MP_LL, MP_LH, MP_HL, MP_SUM
  } thp_mph_t;

  typedef enum logic [1:0] {
    DV_IDLE, DV_RUN, DV_FIX
  } thp_dvst_t;

  function automatic logic [31:0] sx16_32(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx16_64(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8_32(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [63:0] sx32_64(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] x, int unsigned s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int unsigned s);
    return 64'($signed(x) >>> s);
  endfunction

endpackage

/* src/thp_front.sv */
// ----------------------------------------------------------------------------
// thp_front
// Input side: accepts raw sample beats into a short queue for the back end.
// ----------------------------------------------------------------------------
module thp_front import thp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [19:0] in_raw_temp,
  input  logic [19:0] in_raw_press,
  input  logic [15:0] in_raw_humid,
  input  logic        deq,
  output thp_fq_t     fq
);

  thp_raw_t           iq_mem_r [IQ_DEPTH];
  logic [IQ_AW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [IQ_AW:0]     cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == (IQ_AW+1)'(IQ_DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = deq & (cnt_r != '0);

  assign fq.valid = (cnt_r != '0);
  assign fq.item  = iq_mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (IQ_AW+1)'(do_push) - (IQ_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      iq_mem_r[wr_r] <= '{raw_temp: in_raw_temp, raw_press: in_raw_press,
                          raw_humid: in_raw_humid};
    end
  end

endmodule

/* src/thp_mul.sv */
// ----------------------------------------------------------------------------
// thp_mul
// Wrapping 64x64 multiply built from one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module thp_mul import thp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  thp_mph_t    ph_r, ph_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt, pp_r, pp_nxt, prod_r, prod_nxt;
  logic [31:0] cr_r, cr_nxt, x_r, x_nxt;
  logic        done_r, done_nxt;
  logic [31:0] mop_a, mop_b;
  logic [63:0] mp;

  assign mp   = mop_a * mop_b;
  assign done = done_r;
  assign prod = prod_r;

  always_comb begin
    ph_nxt   = ph_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    pp_nxt   = pp_r;
    cr_nxt   = cr_r;
    x_nxt    = x_r;
    prod_nxt = prod_r;
    done_nxt = 1'b0;
    mop_a    = a_r[31:0];
    mop_b    = b_r[31:0];
    case (ph_r)
      MP_IDLE: begin
        if (start) begin
          a_nxt  = a;
          b_nxt  = b;
          ph_nxt = MP_LL;
        end
      end
      MP_LL: begin
        pp_nxt = mp;
        ph_nxt = MP_LH;
      end
      MP_LH: begin
        mop_b  = b_r[63:32];
        cr_nxt = mp[31:0];
        ph_nxt = MP_HL;
      end
      MP_HL: begin
        mop_a  = a_r[63:32];
        x_nxt  = mp[31:0];
        ph_nxt = MP_SUM;
      end
      MP_SUM: begin
        prod_nxt = pp_r + {cr_r + x_r, 32'b0};
        done_nxt = 1'b1;
        ph_nxt   = MP_IDLE;
      end
      default: ph_nxt = MP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= MP_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    pp_r   <= pp_nxt;
    cr_r   <= cr_nxt;
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
  end

endmodule

/* src/thp_div.sv */
// ----------------------------------------------------------------------------
// thp_div
// Signed 64-bit divide, truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module thp_div import thp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] q
);

  thp_dvst_t   st_r, st_nxt;
  logic [63:0] rem_r, rem_nxt, quo_r, quo_nxt, md_r, md_nxt, q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt, done_r, done_nxt;
  logic [64:0] rem_sh, rem_sub;

  assign done    = done_r;
  assign q       = q_r;
  assign rem_sh  = {rem_r, quo_r[63]};
  assign rem_sub = rem_sh - {1'b0, md_r};

  always_comb begin
    st_nxt   = st_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    md_nxt   = md_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    case (st_r)
      DV_IDLE: begin
        if (start) begin
          quo_nxt = num[63] ? 64'd0 - num : num;
          md_nxt  = den[63] ? 64'd0 - den : den;
          neg_nxt = num[63] ^ den[63];
          rem_nxt = '0;
          cnt_nxt = '0;
          st_nxt  = DV_RUN;
        end
      end
      DV_RUN: begin
        // restoring step: subtract when the shifted remainder covers the divisor
        if (!rem_sub[64]) begin
          rem_nxt = rem_sub[63:0];
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[63:0];
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'(DIV_BITS - 1)) begin
          st_nxt = DV_FIX;
        end
      end
      DV_FIX: begin
        q_nxt    = neg_r ? 64'd0 - quo_r : quo_r;
        done_nxt = 1'b1;
        st_nxt   = DV_IDLE;
      end
      default: st_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DV_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    md_r  <= md_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

endmodule

/* src/thp_back.sv */
// ----------------------------------------------------------------------------
// thp_back
// Compensation sequencer: steps the formulas through the shared multiplier
// and divider and queues finished results.
// ----------------------------------------------------------------------------
module thp_back import thp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  thp_coef_t   coef,
  input  thp_fq_t     fq,
  output logic        deq,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_temp_centi,
  output logic [31:0] out_press_q24_8,
  output logic [16:0] out_humid_q22_10,
  output logic        out_press_invalid
);

  thp_state_t  st_r, st_nxt;
  thp_step_t   sp_r, sp_nxt;
  logic [19:0] adt_r, adt_nxt, adp_r, adp_nxt;
  logic [15:0] adh_r, adh_nxt;
  logic [31:0] tf_r, tf_nxt, m_r, m_nxt, press_r, press_nxt;
  logic [31:0] ha_r, ha_nxt, hb_r, hb_nxt, hc_r, hc_nxt;
  logic [31:0] hd_r, hd_nxt, he_r, he_nxt, hv_r, hv_nxt;
  logic [63:0] sq_r, sq_nxt, x2_r, x2_nxt, acc_r, acc_nxt;
  logic [63:0] dv_r, dv_nxt, p_r, p_nxt, y_r, y_nxt;
  logic        inval_r, inval_nxt;

  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_b, prod, div_q;
  logic [31:0] r32;

  logic [31:0] t1_w, t2_w, t3_w, h1_w, h2_w, h3_w, h4_w, h5_w, h6_w;
  logic [63:0] p1_w, p2_w, p3_w, p4_w, p5_w, p6_w, p7_w, p8_w, p9_w;
  logic [31:0] ta_w, td_w, v_w, vs_w, hraw_w;
  logic [63:0] x1_w, ps_w, pnum_w, pfin_w;

  thp_res_t         oq_mem_r [OQ_DEPTH];
  thp_res_t         res_w;
  logic [OQ_AW-1:0] oq_wr_r, oq_wr_nxt, oq_rd_r, oq_rd_nxt;
  logic [OQ_AW:0]   oq_cnt_r, oq_cnt_nxt;
  logic             oq_full, oq_wr, oq_rd;

  thp_mul u_mul (
    .clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(prod)
  );

  thp_div u_div (
    .clk, .rst_n, .start(div_start), .num(prod), .den(dv_r),
    .done(div_done), .q(div_q)
  );

  assign r32 = prod[31:0];

  assign t1_w = {16'b0, coef.temp[15:0]};
  assign t2_w = sx16_32(coef.temp[31:16]);
  assign t3_w = sx16_32(coef.temp[47:32]);
  assign p1_w = {48'b0, coef.press_a[15:0]};
  assign p2_w = sx16_64(coef.press_a[31:16]);
  assign p3_w = sx16_64(coef.press_a[47:32]);
  assign p4_w = sx16_64(coef.press_a[63:48]);
  assign p5_w = sx16_64(coef.press_b[15:0]);
  assign p6_w = sx16_64(coef.press_b[31:16]);
  assign p7_w = sx16_64(coef.press_b[47:32]);
  assign p8_w = sx16_64(coef.press_b[63:48]);
  assign p9_w = sx16_64(coef.mixed[15:0]);
  assign h1_w = {24'b0, coef.mixed[23:16]};
  assign h2_w = sx16_32(coef.mixed[39:24]);
  assign h3_w = {24'b0, coef.mixed[47:40]};
  assign h4_w = sx16_32(coef.humid[15:0]);
  assign h5_w = sx16_32(coef.humid[31:16]);
  assign h6_w = sx8_32(coef.humid[39:32]);

  assign ta_w   = {15'b0, adt_r[19:3]} - {15'b0, coef.temp[15:0], 1'b0};
  assign td_w   = {16'b0, adt_r[19:4]} - t1_w;
  assign x1_w   = sx32_64(tf_r) - PRESS_OFFSET;
  assign v_w    = tf_r - HUM_OFFSET;
  assign vs_w   = asr32(hv_r, 15);
  assign ps_w   = asr64(p_r, 13);
  assign pnum_w = ((PRESS_FULL - {44'b0, adp_r}) << 31) - x2_r;
  assign hraw_w = {2'b0, adh_r, 14'b0} - (h4_w << 20);
  assign pfin_w = asr64(p_r + y_r + asr64(prod, 19), 8) + (p7_w << 4);

  // operand select for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (sp_r)
      SP_TA:   begin mul_a = {32'b0, ta_w}; mul_b = {32'b0, t2_w}; end
      SP_TD:   begin mul_a = {32'b0, td_w}; mul_b = {32'b0, td_w}; end
      SP_TV2:  begin mul_a = {32'b0, m_r};  mul_b = {32'b0, t3_w}; end
      SP_PSQ:  begin mul_a = x1_w;          mul_b = x1_w;          end
      SP_PX2A: begin mul_a = sq_r;          mul_b = p6_w;          end
      SP_PX2B: begin mul_a = x1_w;          mul_b = p5_w;          end
      SP_PX1A: begin mul_a = sq_r;          mul_b = p3_w;          end
      SP_PX1B: begin mul_a = x1_w;          mul_b = p2_w;          end
      SP_PDIV: begin mul_a = PRESS_BIAS + acc_r; mul_b = p1_w;     end
      SP_PNUM: begin mul_a = pnum_w;        mul_b = PRESS_SCALE;   end
      SP_PY1:  begin mul_a = p9_w;          mul_b = ps_w;          end
      SP_PY2:  begin mul_a = y_r;           mul_b = ps_w;          end
      SP_PFIN: begin mul_a = p8_w;          mul_b = p_r;           end
      SP_HA:   begin mul_a = {32'b0, h5_w}; mul_b = {32'b0, v_w};  end
      SP_HB:   begin mul_a = {32'b0, v_w};  mul_b = {32'b0, h6_w}; end
      SP_HC:   begin mul_a = {32'b0, v_w};  mul_b = {32'b0, h3_w}; end
      SP_HD:   begin mul_a = {32'b0, hb_r}; mul_b = {32'b0, hc_r}; end
      SP_HE:   begin mul_a = {32'b0, hd_r}; mul_b = {32'b0, h2_w}; end
      SP_HV:   begin mul_a = {32'b0, ha_r}; mul_b = {32'b0, he_r}; end
      SP_HVS:  begin mul_a = {32'b0, vs_w}; mul_b = {32'b0, vs_w}; end
      SP_HFIN: begin mul_a = {32'b0, hb_r}; mul_b = {32'b0, h1_w}; end
      default: begin mul_a = '0;            mul_b = '0;            end
    endcase
  end

  // sequencer: next state and step write-back
  always_comb begin
    st_nxt    = st_r;
    sp_nxt    = sp_r;
    adt_nxt   = adt_r;
    adp_nxt   = adp_r;
    adh_nxt   = adh_r;
    tf_nxt    = tf_r;
    m_nxt     = m_r;
    press_nxt = press_r;
    ha_nxt    = ha_r;
    hb_nxt    = hb_r;
    hc_nxt    = hc_r;
    hd_nxt    = hd_r;
    he_nxt    = he_r;
    hv_nxt    = hv_r;
    sq_nxt    = sq_r;
    x2_nxt    = x2_r;
    acc_nxt   = acc_r;
    dv_nxt    = dv_r;
    p_nxt     = p_r;
    y_nxt     = y_r;
    inval_nxt = inval_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    deq       = 1'b0;
    oq_wr     = 1'b0;
    case (st_r)
      BK_IDLE: begin
        if (fq.valid) begin
          deq       = 1'b1;
          adt_nxt   = fq.item.raw_temp;
          adp_nxt   = fq.item.raw_press;
          adh_nxt   = fq.item.raw_humid;
          inval_nxt = 1'b0;
          press_nxt = '0;
          sp_nxt    = SP_TA;
          st_nxt    = BK_ISSUE;
        end
      end
      BK_ISSUE: begin
        mul_start = 1'b1;
        st_nxt    = BK_WAIT;
      end
      BK_WAIT: begin
        if (mul_done) begin
          st_nxt = BK_ISSUE;
          case (sp_r)
            SP_TA:   begin tf_nxt = asr32(r32, 11); sp_nxt = SP_TD; end
            SP_TD:   begin m_nxt = asr32(r32, 12); sp_nxt = SP_TV2; end
            SP_TV2:  begin tf_nxt = tf_r + asr32(r32, 14); sp_nxt = SP_PSQ; end
            SP_PSQ:  begin sq_nxt = prod; sp_nxt = SP_PX2A; end
            SP_PX2A: begin x2_nxt = prod; sp_nxt = SP_PX2B; end
            SP_PX2B: begin
              x2_nxt = x2_r + (prod << 17) + (p4_w << 35);
              sp_nxt = SP_PX1A;
            end
            SP_PX1A: begin acc_nxt = asr64(prod, 8); sp_nxt = SP_PX1B; end
            SP_PX1B: begin acc_nxt = acc_r + (prod << 12); sp_nxt = SP_PDIV; end
            SP_PDIV: begin
              dv_nxt = asr64(prod, 33);
              // zero divisor: flag it and skip the pressure tail
              if (dv_nxt == '0) begin
                inval_nxt = 1'b1;
                sp_nxt    = SP_HA;
              end else begin
                sp_nxt = SP_PNUM;
              end
            end
            SP_PNUM: begin
              div_start = 1'b1;
              st_nxt    = BK_DIV;
              sp_nxt    = SP_PY1;
            end
            SP_PY1:  begin y_nxt = prod; sp_nxt = SP_PY2; end
            SP_PY2:  begin y_nxt = asr64(prod, 25); sp_nxt = SP_PFIN; end
            SP_PFIN: begin press_nxt = pfin_w[31:0]; sp_nxt = SP_HA; end
            SP_HA: begin
              ha_nxt = asr32(hraw_w - r32 + HUM_ROUND, 15);
              sp_nxt = SP_HB;
            end
            SP_HB:   begin hb_nxt = asr32(r32, 10); sp_nxt = SP_HC; end
            SP_HC:   begin hc_nxt = asr32(r32, 11) + HUM_HALF; sp_nxt = SP_HD; end
            SP_HD:   begin hd_nxt = asr32(r32, 10) + HUM_BASE; sp_nxt = SP_HE; end
            SP_HE:   begin he_nxt = asr32(r32 + HUM_ROUND2, 14); sp_nxt = SP_HV; end
            SP_HV:   begin hv_nxt = r32; sp_nxt = SP_HVS; end
            SP_HVS:  begin hb_nxt = asr32(r32, 7); sp_nxt = SP_HFIN; end
            SP_HFIN: begin
              hv_nxt = hv_r - asr32(r32, 4);
              st_nxt = BK_PUSH;
            end
            default: st_nxt = BK_IDLE;
          endcase
        end
      end
      BK_DIV: begin
        if (div_done) begin
          p_nxt  = div_q;
          st_nxt = BK_ISSUE;
        end
      end
      BK_PUSH: begin
        if (!oq_full) begin
          oq_wr  = 1'b1;
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // result record
  always_comb begin
    res_w.temp_centi    = asr32((tf_r << 2) + tf_r + TEMP_ROUND, 8);
    res_w.press_q24_8   = press_r;
    res_w.press_invalid = inval_r;
    if (hv_r[31]) begin
      res_w.humid_q22_10 = '0;
    end else if (hv_r > HUM_MAX) begin
      res_w.humid_q22_10 = HUM_MAX[28:12];
    end else begin
      res_w.humid_q22_10 = hv_r[28:12];
    end
  end

  // output queue
  assign oq_full = (oq_cnt_r == (OQ_AW+1)'(OQ_DEPTH));
  assign empty   = (oq_cnt_r == '0);
  assign oq_rd   = pop & ~empty;

  always_comb begin
    oq_wr_nxt  = oq_wr ? oq_wr_r + 1'b1 : oq_wr_r;
    oq_rd_nxt  = oq_rd ? oq_rd_r + 1'b1 : oq_rd_r;
    oq_cnt_nxt = oq_cnt_r + (OQ_AW+1)'(oq_wr) - (OQ_AW+1)'(oq_rd);
  end

  assign out_temp_centi    = oq_mem_r[oq_rd_r].temp_centi;
  assign out_press_q24_8   = oq_mem_r[oq_rd_r].press_q24_8;
  assign out_humid_q22_10  = oq_mem_r[oq_rd_r].humid_q22_10;
  assign out_press_invalid = oq_mem_r[oq_rd_r].press_invalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= BK_IDLE;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      st_r     <= st_nxt;
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sp_r    <= sp_nxt;
    adt_r   <= adt_nxt;
    adp_r   <= adp_nxt;
    adh_r   <= adh_nxt;
    tf_r    <= tf_nxt;
    m_r     <= m_nxt;
    press_r <= press_nxt;
    ha_r    <= ha_nxt;
    hb_r    <= hb_nxt;
    hc_r    <= hc_nxt;
    hd_r    <= hd_nxt;
    he_r    <= he_nxt;
    hv_r    <= hv_nxt;
    sq_r    <= sq_nxt;
    x2_r    <= x2_nxt;
    acc_r   <= acc_nxt;
    dv_r    <= dv_nxt;
    p_r     <= p_nxt;
    y_r     <= y_nxt;
    inval_r <= inval_nxt;
    if (oq_wr) begin
      oq_mem_r[oq_wr_r] <= res_w;
    end
  end

endmodule

/* src/thp_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// thp_sensor_compensation
// Integer temperature, pressure and humidity compensation of raw sensor words.
// ----------------------------------------------------------------------------
// Each raw triple passes through the compensation sequencer: it takes the beat,
// makes 21 passes through one shared 32x32 multiplier, runs a radix-2 divide
// for pressure and hands the result to the result queue. When the pressure
// divisor comes out zero, the divide and the pressure tail are skipped. A full
// result queue holds the sequencer until a result is popped. A 4-deep input
// queue and a 2-deep result queue sit on either side, so new beats are taken
// and finished results wait while the sequencer works. Calibration words must
// be written through the cfg port only while the block is idle; the block
// itself does not enforce this. Unknown register indexes are dropped.
// ----------------------------------------------------------------------------
module thp_sensor_compensation import thp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [19:0] in_raw_temp,
  input  logic [19:0] in_raw_press,
  input  logic [15:0] in_raw_humid,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] out_temp_centi,
  output logic [31:0] out_press_q24_8,
  output logic [16:0] out_humid_q22_10,
  output logic        out_press_invalid,
  // calibration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_wdata
);

  thp_coef_t   coef_r, coef_nxt;
  thp_fq_t     fq;
  logic        deq;
  logic [31:0] temp_w;

  // Calibration registers: decode the index, drop anything past the list.
  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      case (thp_cfg_idx_t'(cfg_idx))
        CFG_TEMP:    coef_nxt.temp    = cfg_wdata[47:0];
        CFG_PRESS_A: coef_nxt.press_a = cfg_wdata;
        CFG_PRESS_B: coef_nxt.press_b = cfg_wdata;
        CFG_MIXED:   coef_nxt.mixed   = cfg_wdata[47:0];
        CFG_HUMID:   coef_nxt.humid   = cfg_wdata[39:0];
        default:     coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // Front end: take beats and hold them until the sequencer is free.
  thp_front u_front (
    .clk, .rst_n, .push, .full,
    .in_raw_temp, .in_raw_press, .in_raw_humid,
    .deq, .fq
  );

  // Back end: sequence the formulas and queue the results.
  thp_back u_back (
    .clk, .rst_n, .coef(coef_r), .fq, .deq,
    .empty, .pop,
    .out_temp_centi(temp_w),
    .out_press_q24_8, .out_humid_q22_10, .out_press_invalid
  );

  assign out_temp_centi = $signed(temp_w);

endmodule

/* src/thp_checker.sv */
// ----------------------------------------------------------------------------
// thp_checker
// Port-level checks on the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thp_checker import thp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic [31:0] out_press_q24_8,
  input logic [16:0] out_humid_q22_10,
  input logic        out_press_invalid
);

  // queues come out of reset drained, and no result can show up that soon
  `THP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> empty ##2 empty)
  `THP_ASSERT_ALWAYS(a_rst_not_full, !rst_n |=> !full)
  // an invalid pressure is always reported as zero
  `THP_ASSERT(a_inval_zero, !empty && out_press_invalid |-> out_press_q24_8 == 32'd0)
  // humidity never leaves the clamp window
  `THP_ASSERT(a_humid_clamp, !empty |-> out_humid_q22_10 <= 17'd102400)

endmodule

bind thp_sensor_compensation thp_checker u_thp_checker (.*);
